FILE: rtl/core/suks_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique key set package
// Shared types and codes for the sorted key set core and its cells.
// ----------------------------------------------------------------------------
package suks_pkg;

  localparam int KEY_W   = 32;
  localparam int POS_W   = 8;
  localparam int TOTAL_W = 9;

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_PRESENT     = 2'd1,
    ST_NOT_PRESENT = 2'd2,
    ST_FULL        = 2'd3
  } status_code_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } phase_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/suks_cell.sv
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key, compares it against the request key and shifts with its
// neighbors on an insert or a remove.
// ----------------------------------------------------------------------------
module suks_cell (
  input  logic                       clk,
  input  suks_pkg::cell_ctrl_t       ctrl,
  input  logic [suks_pkg::KEY_W-1:0] key_in,
  input  logic                       valid,
  input  logic                       left_lt,
  input  logic [suks_pkg::KEY_W-1:0] left_key,
  input  logic [suks_pkg::KEY_W-1:0] right_key,
  output logic [suks_pkg::KEY_W-1:0] key_out,
  output logic                       lt,
  output logic                       eq,
  output logic                       boundary
);
  import suks_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             lt_r, eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= valid && (key_r < key_in);
      eq_r <= valid && (key_r == key_in);
    end
    key_r <= key_nxt;
  end

  // Cells below the point keep their key; on an insert the cell at the point
  // takes the new key and those above the left key; on a remove, the right key.
  always_comb begin
    key_nxt = key_r;
    priority if (ctrl.ins && !lt_r) begin
      key_nxt = left_lt ? key_in : left_key;
    end else if (ctrl.rem && !lt_r) begin
      key_nxt = right_key;
    end
  end

  assign key_out  = key_r;
  assign lt       = lt_r;
  assign eq       = eq_r;
  assign boundary = !lt_r && left_lt;

endmodule

FILE: rtl/core/suks_encoder.sv
// ----------------------------------------------------------------------------
// Sorted key set position encoder
// Turns the one-hot boundary flags of the cell row into a binary index.
// ----------------------------------------------------------------------------
module suks_encoder #(
  parameter int N  = 256,
  parameter int IW = 8
) (
  input  logic [N-1:0]  boundary,
  output logic [IW-1:0] idx
);
  import suks_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (boundary[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

FILE: rtl/core/sorted_unique_key_set_core.sv
// ----------------------------------------------------------------------------
// Sorted unique key set core
// Row of key cells with find, add and remove of unique keys in ascending order.
// ----------------------------------------------------------------------------
// A request passes a compare phase, in which every cell compares its key, then
// an update phase, in which the cells from the point up shift by one place on
// an add or remove; the next request may be taken in the update phase.
// Reset: synchronous, active low; the set starts empty with no result pending.
// Results are shown for one cycle only; the receiver cannot stall them.
module sorted_unique_key_set_core #(
  parameter int CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  suks_pkg::req_t in_req,
  output logic           out_valid,
  output suks_pkg::rsp_t out_rsp
);
  import suks_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  phase_t         phase_r, phase_nxt;
  req_t           req_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r;
  rsp_t           out_rsp_r, rsp_nxt;
  cell_ctrl_t     ctrl;
  logic           accept;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_lt, cell_eq, cell_bnd, cell_valid;
  logic [IW-1:0]  idx;
  logic           present, full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    logic             left_lt;

    assign cell_valid[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_key = in_req.key;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    suks_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key_in    (req_r.key),
      .valid     (cell_valid[i]),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key_out   (cell_key[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i]),
      .boundary  (cell_bnd[i])
    );
  end

  suks_encoder #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_encoder (
    .boundary (cell_bnd),
    .idx      (idx)
  );

  assign present = |cell_eq;
  assign full    = (count_r == CW'(CAPACITY));
  assign busy    = (phase_r == PH_CMP);
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (phase_r == PH_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (phase_r == PH_UPD) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  // The update phase may take the next request, which then compares
  // against the shifted row in the following cycle.
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    ctrl        = '0;
    rsp_nxt     = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          phase_nxt = PH_CMP;
        end
      end
      PH_CMP: begin
        ctrl.cmp_en = 1'b1;
        phase_nxt   = PH_UPD;
      end
      PH_UPD: begin
        phase_nxt = accept ? PH_CMP : PH_IDLE;
        unique case (req_code_t'(req_r.req_type))
          REQ_ADD: begin
            priority if (present) begin
              rsp_nxt.status   = ST_PRESENT;
              rsp_nxt.position = POS_W'(idx);
            end else if (full) begin
              rsp_nxt.status   = ST_FULL;
            end else begin
              ctrl.ins         = 1'b1;
              count_nxt        = count_r + CW'(1);
              rsp_nxt.status   = ST_DONE;
              rsp_nxt.position = POS_W'(idx);
            end
          end
          REQ_REMOVE: begin
            if (present) begin
              ctrl.rem         = 1'b1;
              count_nxt        = count_r - CW'(1);
              rsp_nxt.status   = ST_DONE;
              rsp_nxt.position = POS_W'(idx);
            end else begin
              rsp_nxt.status   = ST_NOT_PRESENT;
            end
          end
          REQ_FIND, REQ_UNUSED: begin
            if (present) begin
              rsp_nxt.status   = ST_DONE;
              rsp_nxt.position = POS_W'(idx);
            end else begin
              rsp_nxt.status   = ST_NOT_PRESENT;
            end
          end
          default: begin
            rsp_nxt.status = ST_NOT_PRESENT;
          end
        endcase
        rsp_nxt.entry_total = TOTAL_W'(count_nxt);
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: dv/tb_sorted_unique_key_set_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set core testbench
// Drives find, add and remove requests through the start/busy port. A shadow
// sorted key list predicts status, position and key total for each request,
// and every strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_unique_key_set_core;
  import suks_pkg::*;

  localparam int CAPACITY = 256;

  class key_set_scoreboard;
    logic [KEY_W-1:0] held_keys[$];
    rsp_t             pending_rsps[$];
    int               mismatches;
    int               checked;
    int               peak_total;
    int               status_seen[4];

    function new();
      mismatches = 0;
      checked    = 0;
      peak_total = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Updates the shadow list for one accepted request and queues its result.
    function void note_request(req_t r);
      req_code_t        op;
      logic [KEY_W-1:0] k;
      int               lo;
      int               hi;
      int               mid;
      bit               found;
      rsp_t             rsp;
      op = req_code_t'(r.req_type);
      k  = r.key;
      lo = 0;
      hi = held_keys.size();
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (held_keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      found = (lo < held_keys.size()) && (held_keys[lo] == k);
      rsp.status   = ST_DONE;
      rsp.position = POS_W'(lo);
      case (op)
        REQ_ADD: begin
          if (found) begin
            rsp.status = ST_PRESENT;
          end else if (held_keys.size() >= CAPACITY) begin
            rsp.status   = ST_FULL;
            rsp.position = '0;
          end else begin
            held_keys.insert(lo, k);
          end
        end
        REQ_REMOVE: begin
          if (found) begin
            held_keys.delete(lo);
          end else begin
            rsp.status   = ST_NOT_PRESENT;
            rsp.position = '0;
          end
        end
        // The unused code behaves as a find.
        default: begin
          if (!found) begin
            rsp.status   = ST_NOT_PRESENT;
            rsp.position = '0;
          end
        end
      endcase
      rsp.entry_total = TOTAL_W'(held_keys.size());
      if (held_keys.size() > peak_total) peak_total = held_keys.size();
      status_seen[rsp.status]++;
      pending_rsps.push_back(rsp);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting: %p", got));
      end else begin
        want = pending_rsps.pop_front();
        checked++;
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    got.position, want.position));
        if (got.entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total %0d, expected %0d",
                                    got.entry_total, want.entry_total));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  key_set_scoreboard sb;
  bit gaps_on = 1'b1;
  int requests_sent = 0;

  sorted_unique_key_set_core #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_response(out_rsp);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_request(req_code_t op, logic [KEY_W-1:0] k);
    while (gaps_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= '{req_type: op, key: k};
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    requests_sent++;
  endtask

  function req_code_t pick_op(int add_pct, int rem_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < add_pct) return REQ_ADD;
    if (roll < add_pct + rem_pct) return REQ_REMOVE;
    if (roll < add_pct + rem_pct + 5) return REQ_UNUSED;
    return REQ_FIND;
  endfunction

  // Held keys give hits; their neighbors probe the ordering around them.
  function logic [KEY_W-1:0] pick_key(int held_pct);
    logic [KEY_W-1:0] k;
    int               roll;
    roll = $urandom_range(99);
    if (sb.held_keys.size() > 0 && roll < held_pct + 10) begin
      k = sb.held_keys[$urandom_range(sb.held_keys.size() - 1)];
      if (roll >= held_pct) k = $urandom_range(1) ? k + 1 : k - 1;
      return k;
    end
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Stops after count requests, or once the set holds stop_total keys.
  task run_random(int count, int add_pct, int rem_pct, int held_pct, int stop_total);
    for (int n = 0; n < count; n++) begin
      if (sb.held_keys.size() == stop_total) break;
      send_request(pick_op(add_pct, rem_pct), pick_key(held_pct));
    end
  endtask

  initial begin
    sb     = new();
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty set, extremes of the key range, duplicates and absent keys.
    send_request(REQ_FIND,   32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0000_0005);
    send_request(REQ_ADD,    32'h8000_0000);
    send_request(REQ_ADD,    32'h0000_0000);
    send_request(REQ_ADD,    32'hFFFF_FFFF);
    send_request(REQ_ADD,    32'h7FFF_FFFF);
    send_request(REQ_ADD,    32'h8000_0000);
    send_request(REQ_FIND,   32'hFFFF_FFFF);
    send_request(REQ_FIND,   32'h0000_0000);
    send_request(REQ_FIND,   32'h0000_0001);
    send_request(REQ_UNUSED, 32'h7FFF_FFFF);
    send_request(REQ_UNUSED, 32'hAAAA_5555);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_ADD,    32'h8000_0001);
    send_request(REQ_ADD,    32'h7FFF_FFFF);
    send_request(REQ_ADD,    32'h5555_AAAA);
    send_request(REQ_FIND,   32'h8000_0001);

    run_random(500, 35, 25, 60, -1);
    // Fill to capacity back to back, then hammer the full set.
    gaps_on = 1'b0;
    run_random(700, 90, 3, 10, CAPACITY);
    gaps_on = 1'b1;
    run_random(150, 50, 10, 40, -1);
    run_random(700, 5, 85, 85, 0);
    if (requests_sent < 1825) run_random(1825 - requests_sent, 35, 25, 60, -1);
    start <= 1'b0;

    for (int w = 0; w < 200 && sb.pending_rsps.size() > 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    while (sb.pending_rsps.size() > 0) begin
      void'(sb.pending_rsps.pop_front());
      sb.report_mismatch("expected result never arrived");
    end

    $display("Ran %0d requests, %0d results checked, set peaked at %0d of %0d keys.",
             requests_sent, sb.checked, sb.peak_total, CAPACITY);
    $display("Outcomes: %0d done, %0d already present, %0d not present, %0d full.",
             sb.status_seen[ST_DONE], sb.status_seen[ST_PRESENT],
             sb.status_seen[ST_NOT_PRESENT], sb.status_seen[ST_FULL]);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timed out waiting for the block.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/suks_pkg.sv
rtl/core/suks_cell.sv
rtl/core/suks_encoder.sv
rtl/core/sorted_unique_key_set_core.sv
dv/tb_sorted_unique_key_set_core.sv
